>>> hw/rtl/sidac_pkg.sv
// ----------------------------------------------------------------------------
// sidac_pkg
// Shared widths and ASCII codes for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package sidac_pkg;

	// Width of the signed input value
	localparam int VALUE_BITS = 32;
	// Width of the buffer capacity field
	localparam int LEN_BITS   = 8;
	// Output field widths
	localparam int CHAR_BITS  = 7;
	localparam int TLEN_BITS  = 4;

	// Binary bits consumed by one shift-add-3 stage
	localparam int STEP_BITS  = 8;
	localparam int DAB_STAGES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_BITS   = DAB_STAGES * STEP_BITS;

	// Decimal digits needed for the largest magnitude, 2**(VALUE_BITS-1)
	function automatic int digit_count(input int bits);
		logic [64:0] m;
		int          n;
		m = 65'd1 << (bits - 1);
		n = 0;
		while (m != 65'd0) begin
			m = m / 10;
			n = n + 1;
		end
		return n;
	endfunction

	localparam int DIGITS       = digit_count(VALUE_BITS);
	localparam int BCD_BITS     = DIGITS * 4;
	localparam int DAB_W        = BCD_BITS + PAD_BITS;
	localparam int DCNT_BITS    = $clog2(DIGITS + 1);
	localparam int DIG_IDX_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int RCNT_BITS    = $clog2(DIGITS + 2);

	// ASCII codes
	localparam logic [CHAR_BITS-1:0] ASCII_NUL   = 7'h00;
	localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 7'h30;
	localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 7'h2d;

endpackage

>>> hw/rtl/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed value to NUL-terminated decimal ASCII text, one character
// per strobe, keeping the lowest-order digits that fit the buffer capacity.
// A word passes the input, sign, shift-add-3, plan and serializer stages.
// Throughput: one character per cycle through the single output register; a
// word is 1 to 12 characters long in the serializer (sign, digits, NUL).
// Conversion runs in a shift-add-3 pipeline (one stage per 8 value bits) that
// keeps accepting words while the serializer drains the previous one.
// Reset clears all pipeline valid bits and the strobe; no memory needs clearing.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core import sidac_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic        [LEN_BITS-1:0]   buffer_len,
	output logic                         strobe,
	output logic        [CHAR_BITS-1:0]  character,
	output logic                         char_valid,
	output logic                         last,
	output logic        [TLEN_BITS-1:0]  text_length
);

	// Eight shift-add-3 steps on the packed {bcd, binary} word
	function automatic logic [DAB_W-1:0] dab_chunk(input logic [DAB_W-1:0] w);
		logic [DAB_W-1:0] t;
		t = w;
		for (int j = 0; j < STEP_BITS; j++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (t[PAD_BITS + 4*d +: 4] >= 4'd5) begin
					t[PAD_BITS + 4*d +: 4] = t[PAD_BITS + 4*d +: 4] + 4'd3;
				end
			end
			t = t << 1;
		end
		return t;
	endfunction

	// ------------------------------------------------------------------
	// Declarations
	// ------------------------------------------------------------------
	logic                       accept;
	logic                       s1_rdy, s2_rdy, pl_rdy;

	logic                       v_s1;
	logic [VALUE_BITS-1:0]      val_s1;
	logic [LEN_BITS-1:0]        cap_s1;

	logic                       v_s2;
	logic                       neg_s2;
	logic [PAD_BITS-1:0]        mag_s2;
	logic [LEN_BITS-1:0]        cap_s2;
	logic [VALUE_BITS-1:0]      mag_c;

	logic                       dab_v_s   [DAB_STAGES];
	logic [DAB_W-1:0]           dab_w_s   [DAB_STAGES];
	logic                       dab_neg_s [DAB_STAGES];
	logic [LEN_BITS-1:0]        dab_cap_s [DAB_STAGES];
	logic                       dab_rdy   [DAB_STAGES];

	logic [BCD_BITS-1:0]        dab_bcd;
	logic [DCNT_BITS-1:0]       nsig_c;

	logic                       pl_v_sl;
	logic [BCD_BITS-1:0]        pl_bcd_sl;
	logic                       pl_neg_sl;
	logic [LEN_BITS-1:0]        pl_cap_sl;
	logic [DCNT_BITS-1:0]       pl_nsig_sl;

	logic                       ser_act_q;
	logic                       ser_sign_q;
	logic [DCNT_BITS-1:0]       ser_left_q;
	logic                       ser_wr_q;
	logic [RCNT_BITS-1:0]       ser_len_q;
	logic [BCD_BITS-1:0]        ser_bcd_q;
	logic                       ser_term;
	logic                       ser_load;
	logic [3:0]                 ser_dig [DIGITS];
	logic [DIG_IDX_BITS-1:0]    ser_idx;
	logic                       cap0, cap1;
	logic [LEN_BITS-1:0]        room_c;
	logic [DCNT_BITS-1:0]       nd_c;

	logic                       strobe_q;
	logic [CHAR_BITS-1:0]       char_q;
	logic                       cvalid_q;
	logic                       last_q;
	logic [TLEN_BITS-1:0]       tlen_q;

	// ------------------------------------------------------------------
	// Ready chain, back from the serializer
	// ------------------------------------------------------------------
	assign ser_term = ser_act_q && !ser_sign_q && (ser_left_q == '0);
	assign ser_load = pl_v_sl && (!ser_act_q || ser_term);
	assign pl_rdy   = !pl_v_sl || !ser_act_q || ser_term;
	assign s2_rdy   = !v_s2 || dab_rdy[0];
	assign s1_rdy   = !v_s1 || s2_rdy;
	assign busy     = !s1_rdy;
	assign accept   = start && !busy;

	// ------------------------------------------------------------------
	// Stage 1: capture the word
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_rdy) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_s1 <= value;
			cap_s1 <= buffer_len;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: sign and magnitude (most negative value wraps to 2**(N-1))
	// ------------------------------------------------------------------
	assign mag_c = val_s1[VALUE_BITS-1] ? (~val_s1 + 1'b1) : val_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_rdy) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_rdy && v_s1) begin
			neg_s2 <= val_s1[VALUE_BITS-1];
			mag_s2 <= PAD_BITS'(mag_c);
			cap_s2 <= cap_s1;
		end
	end

	// ------------------------------------------------------------------
	// Shift-add-3 stages, STEP_BITS value bits each
	// ------------------------------------------------------------------
	for (genvar k = 0; k < DAB_STAGES; k++) begin : g_dab
		logic                prev_v;
		logic [DAB_W-1:0]    prev_w;
		logic                prev_neg;
		logic [LEN_BITS-1:0] prev_cap;
		logic                next_rdy;

		if (k == 0) begin : g_first
			assign prev_v   = v_s2;
			assign prev_w   = {{BCD_BITS{1'b0}}, mag_s2};
			assign prev_neg = neg_s2;
			assign prev_cap = cap_s2;
		end else begin : g_mid
			assign prev_v   = dab_v_s[k-1];
			assign prev_w   = dab_w_s[k-1];
			assign prev_neg = dab_neg_s[k-1];
			assign prev_cap = dab_cap_s[k-1];
		end

		if (k == DAB_STAGES - 1) begin : g_tail
			assign next_rdy = pl_rdy;
		end else begin : g_body
			assign next_rdy = dab_rdy[k+1];
		end

		assign dab_rdy[k] = !dab_v_s[k] || next_rdy;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dab_v_s[k] <= 1'b0;
			end else if (dab_rdy[k]) begin
				dab_v_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (dab_rdy[k] && prev_v) begin
				dab_w_s[k]   <= dab_chunk(prev_w);
				dab_neg_s[k] <= prev_neg;
				dab_cap_s[k] <= prev_cap;
			end
		end
	end

	// ------------------------------------------------------------------
	// Plan stage: count significant digits (zero counts as one digit)
	// ------------------------------------------------------------------
	assign dab_bcd = dab_w_s[DAB_STAGES-1][DAB_W-1 -: BCD_BITS];

	always_comb begin
		nsig_c = DCNT_BITS'(1);
		for (int d = 0; d < DIGITS; d++) begin
			if (dab_bcd[4*d +: 4] != 4'd0) begin
				nsig_c = DCNT_BITS'(d + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_v_sl <= 1'b0;
		end else if (pl_rdy) begin
			pl_v_sl <= dab_v_s[DAB_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pl_rdy && dab_v_s[DAB_STAGES-1]) begin
			pl_bcd_sl  <= dab_bcd;
			pl_neg_sl  <= dab_neg_s[DAB_STAGES-1];
			pl_cap_sl  <= dab_cap_s[DAB_STAGES-1];
			pl_nsig_sl <= nsig_c;
		end
	end

	// ------------------------------------------------------------------
	// Serializer load values: digits kept = min(significant, room)
	// ------------------------------------------------------------------
	assign cap0   = (pl_cap_sl == '0);
	assign cap1   = (pl_cap_sl == LEN_BITS'(1));
	assign room_c = pl_cap_sl - LEN_BITS'(1) - LEN_BITS'(pl_neg_sl);
	assign nd_c   = (room_c < LEN_BITS'(pl_nsig_sl)) ? DCNT_BITS'(room_c) : pl_nsig_sl;

	// Digit view of the held BCD word
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			ser_dig[d] = ser_bcd_q[4*d +: 4];
		end
	end
	assign ser_idx = DIG_IDX_BITS'(ser_left_q - 1'b1);

	// ------------------------------------------------------------------
	// Serializer: sign, digits high to low, then terminator
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_act_q  <= 1'b0;
			ser_sign_q <= 1'b0;
			ser_left_q <= '0;
			ser_len_q  <= '0;
			ser_wr_q   <= 1'b0;
		end else begin
			if (ser_act_q) begin
				if (ser_sign_q) begin
					ser_sign_q <= 1'b0;
					ser_len_q  <= ser_len_q + 1'b1;
				end else if (ser_left_q != '0) begin
					ser_left_q <= ser_left_q - 1'b1;
					ser_len_q  <= ser_len_q + 1'b1;
				end else begin
					ser_act_q <= 1'b0;
				end
			end
			if (ser_load) begin
				ser_act_q  <= 1'b1;
				ser_sign_q <= pl_neg_sl && !cap0 && !cap1;
				ser_left_q <= (cap0 || cap1) ? '0 : nd_c;
				ser_wr_q   <= !cap0;
				ser_len_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			ser_bcd_q <= pl_bcd_sl;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ser_act_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_act_q) begin
			if (ser_sign_q) begin
				char_q   <= ASCII_MINUS;
				cvalid_q <= 1'b1;
				last_q   <= 1'b0;
				tlen_q   <= '0;
			end else if (ser_left_q != '0) begin
				char_q   <= ASCII_ZERO + CHAR_BITS'(ser_dig[ser_idx]);
				cvalid_q <= 1'b1;
				last_q   <= 1'b0;
				tlen_q   <= '0;
			end else begin
				char_q   <= ASCII_NUL;
				cvalid_q <= ser_wr_q;
				last_q   <= 1'b1;
				tlen_q   <= TLEN_BITS'(ser_len_q);
			end
		end
	end

	assign strobe      = strobe_q;
	assign character   = char_q;
	assign char_valid  = cvalid_q;
	assign last        = last_q;
	assign text_length = tlen_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_strobe_from_ser: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(ser_act_q))
		else $error("strobe without an active serializer");

	a_mid_is_written: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> char_valid)
		else $error("unwritten character before the terminator");

	a_nowrite_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !char_valid) |-> (last && text_length == '0))
		else $error("zero-capacity word reported text");

	a_plan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pl_v_sl && !pl_rdy) |=> (pl_v_sl && $stable(pl_bcd_sl) && $stable(pl_cap_sl)))
		else $error("plan stage lost data while stalled");

	a_stage1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && busy) |=> (v_s1 && $stable(val_s1) && $stable(cap_s1)))
		else $error("input stage changed while stalled");

endmodule

>>> dv/signed_int_to_decimal_ascii_core_test.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_test
// Self-checking bench for the signed integer to decimal text core. Words are
// queued by a stimulus block, sent by a clocked driver with random idle gaps,
// and every character strobe is checked against an in-bench spelling of the
// value under the buffer capacity of its word.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_test import sidac_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_WORDS = 340;
	localparam int TAIL_CYCLES  = 40;

	// One queued input word plus its lead-in idle cycles
	typedef struct {
		logic signed [VALUE_BITS-1:0] value;
		logic        [LEN_BITS-1:0]   cap;
		int unsigned                  gap;
		bit                           drain;
	} text_word_t;

	// One expected character strobe
	typedef struct {
		logic [CHAR_BITS-1:0] character;
		logic                 char_valid;
		logic                 last;
		logic [TLEN_BITS-1:0] text_length;
	} text_char_t;

	bit                           clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         busy;
	logic signed [VALUE_BITS-1:0] value = '0;
	logic        [LEN_BITS-1:0]   buffer_len = '0;
	logic                         strobe;
	logic        [CHAR_BITS-1:0]  character;
	logic                         char_valid;
	logic                         last;
	logic        [TLEN_BITS-1:0]  text_length;

	text_word_t  pending_words[$];
	text_char_t  expected_chars[$];
	text_char_t  want;
	int unsigned words_sent;
	int unsigned chars_checked;
	int unsigned clipped_words;
	int unsigned mismatches;
	int unsigned cycles;

	signed_int_to_decimal_ascii_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.buffer_len  (buffer_len),
		.strobe      (strobe),
		.character   (character),
		.char_valid  (char_valid),
		.last        (last),
		.text_length (text_length)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic text_char_t mk_char(logic [CHAR_BITS-1:0] ch, logic vld, logic lst,
			logic [TLEN_BITS-1:0] len);
		text_char_t c;
		c.character   = ch;
		c.char_valid  = vld;
		c.last        = lst;
		c.text_length = len;
		return c;
	endfunction

	// Spell one word into the expected character stream
	task automatic spell_decimal(input logic signed [VALUE_BITS-1:0] v,
			input logic [LEN_BITS-1:0] cap);
		logic [VALUE_BITS:0] mag;
		logic [3:0]          digits[$];
		bit                  neg;
		int                  room;
		int                  k;
		neg = v[VALUE_BITS-1];
		// most negative value comes out as 2**(VALUE_BITS-1) in the wider vector
		mag = neg ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
		if (cap == 0) begin
			expected_chars.push_back(mk_char(ASCII_NUL, 1'b0, 1'b1, '0));
			return;
		end
		if (cap == 1) begin
			expected_chars.push_back(mk_char(ASCII_NUL, 1'b1, 1'b1, '0));
			return;
		end
		if (mag == 0) begin
			expected_chars.push_back(mk_char(ASCII_ZERO, 1'b1, 1'b0, '0));
			expected_chars.push_back(mk_char(ASCII_NUL, 1'b1, 1'b1, 4'd1));
			return;
		end
		room = int'(cap) - 1 - int'(neg);
		// low-order digits first, kept in reading order
		while (mag != 0 && digits.size() < room) begin
			digits.push_front(4'(mag % 10));
			mag = mag / 10;
		end
		if (mag != 0)
			clipped_words++;
		k = 0;
		if (neg) begin
			expected_chars.push_back(mk_char(ASCII_MINUS, 1'b1, 1'b0, '0));
			k++;
		end
		foreach (digits[i]) begin
			expected_chars.push_back(mk_char(ASCII_ZERO + CHAR_BITS'(digits[i]), 1'b1, 1'b0,
				'0));
			k++;
		end
		expected_chars.push_back(mk_char(ASCII_NUL, 1'b1, 1'b1, TLEN_BITS'(k)));
	endtask

	task automatic queue_word(logic signed [VALUE_BITS-1:0] v, logic [LEN_BITS-1:0] cap,
			int unsigned gap, bit drain);
		text_word_t w;
		w.value = v;
		w.cap   = cap;
		w.gap   = gap;
		w.drain = drain;
		pending_words.push_back(w);
	endtask

	// Values biased toward digit-count boundaries and the extremes
	function automatic logic signed [VALUE_BITS-1:0] pick_value();
		logic signed [VALUE_BITS-1:0] v;
		longint                       p;
		int                           n;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 400) - 200;
			1: begin
				p = 1;
				n = $urandom_range(0, 9);
				repeat (n) p = p * 10;
				v = VALUE_BITS'(p + $urandom_range(0, 2) - 1);
				if ($urandom_range(0, 1))
					v = -v;
			end
			2: begin
				case ($urandom_range(0, 3))
					0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
					1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
					2: v = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
					default: v = {1'b0, {(VALUE_BITS-2){1'b1}}, 1'b0};
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Driver: present queued words, hold until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			value      <= '0;
			buffer_len <= '0;
		end else begin
			if (start && !busy) begin
				spell_decimal(value, buffer_len);
				words_sent++;
			end
			if (!(start && busy)) begin
				if (pending_words.size() == 0) begin
					start <= 1'b0;
				end else if (pending_words[0].gap != 0) begin
					pending_words[0].gap = pending_words[0].gap - 1;
					start <= 1'b0;
				end else if (pending_words[0].drain && expected_chars.size() != 0) begin
					// let the output side run dry first
					start <= 1'b0;
				end else begin
					value      <= pending_words[0].value;
					buffer_len <= pending_words[0].cap;
					start      <= 1'b1;
					void'(pending_words.pop_front());
				end
			end
		end
	end

	// Monitor: compare each strobe with the oldest expected character
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected strobe: character=%0h char_valid=%0b last=%0b text_length=%0d",
					character, char_valid, last, text_length);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				chars_checked++;
				if (character !== want.character) begin
					$error("character: expected %0h, got %0h", want.character, character);
					mismatches++;
				end
				if (char_valid !== want.char_valid) begin
					$error("char_valid: expected %0b, got %0b", want.char_valid, char_valid);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					mismatches++;
				end
				if (text_length !== want.text_length) begin
					$error("text_length: expected %0d, got %0d", want.text_length,
						text_length);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("signed_int_to_decimal_ascii_core verification failed");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		logic signed [VALUE_BITS-1:0] v_min;
		logic signed [VALUE_BITS-1:0] v_max;
		logic [LEN_BITS-1:0]          cap;
		bit                           burst;
		v_min = {1'b1, {(VALUE_BITS-1){1'b0}}};
		v_max = {1'b0, {(VALUE_BITS-1){1'b1}}};

		// directed: zero, unit values, extremes, clipping and tiny capacities
		queue_word(0, 0, 0, 0);
		queue_word(0, 1, 0, 0);
		queue_word(0, 2, 3, 0);
		queue_word(0, 255, 0, 0);
		queue_word(-1, 0, 0, 0);
		queue_word(-1, 1, 1, 0);
		queue_word(-1, 2, 0, 0);
		queue_word(-1, 3, 0, 0);
		queue_word(1, 2, 0, 0);
		queue_word(v_max, 11, 5, 0);
		queue_word(v_max, 10, 0, 0);
		queue_word(v_max, 255, 0, 0);
		queue_word(v_min, 12, 0, 0);
		queue_word(v_min, 11, 2, 0);
		queue_word(v_min, 2, 0, 0);
		queue_word(v_min, 255, 0, 0);
		queue_word(v_min, 1, 0, 0);
		queue_word(v_min, 0, 0, 0);
		queue_word(-123456789, 5, 0, 0);
		queue_word(1000000000, 12, 0, 0);
		queue_word(-5, 128, 0, 0);
		queue_word(9, 3, 0, 0);
		queue_word(10, 2, 0, 0);
		queue_word(-1000000000, 13, 0, 1);

		// random: mostly short capacities, some across the full byte
		burst = 1'b0;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 30 == 0)
				burst = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 3) == 0)
				cap = $urandom_range(0, 255);
			else
				cap = $urandom_range(0, 13);
			queue_word(pick_value(), cap, burst ? 0 : $urandom_range(0, 15), (i % 90 == 45));
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_words.size() != 0 || start)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d words (%0d clipped by capacity), checked %0d characters.",
			words_sent, clipped_words, chars_checked);
		$display("Covered zero, both extremes, capacities 0 to 255 and idle gaps 0 to 15.");
		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("signed_int_to_decimal_ascii_core verification clean");
		end else begin
			$display("signed_int_to_decimal_ascii_core verification failed");
		end
		$finish;
	end

endmodule
